FILE: src/blms_pkg.sv
// shared constants, types and saturation helper for the block lms adaptive fir
// no dependencies; imported by the controller, datapath and top level
package blms_pkg;

    // filter length and derived sizes
    localparam int TAPS     = 6;
    localparam int HIST_LEN = 2 * TAPS - 1;
    localparam int HIST_W   = $clog2(HIST_LEN);
    localparam int TAP_W    = (TAPS > 2) ? $clog2(TAPS) : 1;
    localparam int ACC_W    = 33 + $clog2(TAPS);

    // q15 limits and register reset value
    localparam logic signed [15:0] Q15_MAX    = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN    = -16'sh8000;
    localparam logic        [14:0] STEP_RESET = 15'd3;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_FIR  = 2'd0,
        MUL_GRAD = 2'd1,
        MUL_STEP = 2'd2
    } mul_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_in;
        logic              acc_clr;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic [HIST_W-1:0] idx_a;
        logic [TAP_W-1:0]  idx_b;
        logic              out_load;
        logic              last;
        logic              grad_load;
        logic              coef_we;
        logic              hist_shift;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } stat_t;

    // saturate a sign-extended value to q15
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic upper_zero;
        logic upper_ones;
        begin
            upper_zero = ~(|v[ACC_W-2:15]);
            upper_ones = &v[ACC_W-2:15];
            if (!v[ACC_W-1] && !upper_zero)
            begin
                return Q15_MAX;
            end
            else if (v[ACC_W-1] && !upper_ones)
            begin
                return Q15_MIN;
            end
            else
            begin
                return v[15:0];
            end
        end
    endfunction

endpackage

FILE: src/blms_if.sv
// valid/ready channel interfaces for input and result beats
// depends on nothing
interface blms_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mic_sample;
    logic signed [15:0] reference_sample;

    modport source (output valid, output mic_sample, output reference_sample, input ready);
    modport sink   (input valid, input mic_sample, input reference_sample, output ready);
endinterface

interface blms_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_sample;
    logic signed [15:0] error_sample;
    logic               block_end;

    modport source (output valid, output filtered_sample, output error_sample,
                    output block_end, input ready);
    modport sink   (input valid, input filtered_sample, input error_sample,
                    input block_end, output ready);
endinterface

FILE: src/blms_datapath.sv
// datapath: sample history, coefficients, block errors, shared mac and output register
// depends on blms_pkg; driven by blms_ctrl commands
module blms_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  blms_pkg::cmd_t            cmd,
    output blms_pkg::stat_t           stat,
    input  logic                      cfg_we,
    input  logic [14:0]               cfg_data,
    input  logic signed [15:0]        mic_sample,
    input  logic signed [15:0]        reference_sample,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [15:0]        filtered_sample,
    output logic signed [15:0]        error_sample,
    output logic                      block_end
);
    import blms_pkg::*;

    logic signed [15:0]      hist_reg [HIST_LEN];
    logic signed [15:0]      coef_reg [TAPS];
    logic signed [15:0]      err_reg  [TAPS];
    logic signed [15:0]      ref_reg;
    logic [14:0]             step_reg;
    logic signed [31:0]      prod_reg;
    logic signed [31:0]      prod_next;
    logic                    acc_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_shift;
    logic signed [15:0]      grad_reg;
    logic signed [15:0]      mul_a;
    logic signed [15:0]      mul_b;
    logic signed [15:0]      y_val;
    logic signed [15:0]      e_val;
    logic signed [15:0]      delta;
    logic signed [15:0]      coef_new;
    logic signed [16:0]      coef_sum;
    logic                    out_valid_reg;
    logic signed [15:0]      out_y_reg;
    logic signed [15:0]      out_e_reg;
    logic                    out_last_reg;

    // step size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_data;
        end
    end

    // multiplier operand select and product
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_FIR:
            begin
                mul_a = hist_reg[cmd.idx_a];
                mul_b = coef_reg[cmd.idx_b];
            end
            MUL_GRAD:
            begin
                mul_a = hist_reg[cmd.idx_a];
                mul_b = err_reg[cmd.idx_b];
            end
            MUL_STEP:
            begin
                mul_a = signed'({1'b0, step_reg});
                mul_b = grad_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // product register and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            acc_vld_reg <= cmd.mul_en && (cmd.mul_sel != MUL_STEP);
            if (cmd.acc_clr)
            begin
                acc_reg <= '0;
            end
            else if (acc_vld_reg)
            begin
                acc_reg <= acc_reg + {{(ACC_W-32){prod_reg[31]}}, prod_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.grad_load)
        begin
            grad_reg <= y_val;
        end
        if (cmd.load_in)
        begin
            ref_reg <= reference_sample;
        end
    end

    // scaled sum, error and coefficient update values
    always_comb
    begin
        acc_shift = acc_reg >>> 15;
        y_val     = sat16(acc_shift);
        e_val     = ref_reg - y_val;
        delta     = sat16({{(ACC_W-17){prod_reg[31]}}, prod_reg[31:15]});
        coef_sum  = {coef_reg[cmd.idx_b][15], coef_reg[cmd.idx_b]} + {delta[15], delta};
        if (coef_sum[16] != coef_sum[15])
        begin
            coef_new = coef_sum[16] ? Q15_MIN : Q15_MAX;
        end
        else
        begin
            coef_new = coef_sum[15:0];
        end
    end

    // sample history: new sample write and end-of-block shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < HIST_LEN; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else if (cmd.hist_shift)
        begin
            for (int j = 0; j < TAPS - 1; j++)
            begin
                hist_reg[j] <= hist_reg[TAPS + j];
            end
        end
        else if (cmd.load_in)
        begin
            hist_reg[cmd.idx_a] <= mic_sample;
        end
    end

    // coefficients and block errors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                coef_reg[j] <= '0;
                err_reg[j]  <= '0;
            end
        end
        else
        begin
            if (cmd.coef_we)
            begin
                coef_reg[cmd.idx_b] <= coef_new;
            end
            if (cmd.out_load)
            begin
                err_reg[cmd.idx_b] <= e_val;
            end
        end
    end

    // output register, holds a beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_y_reg    <= y_val;
            out_e_reg    <= e_val;
            out_last_reg <= cmd.last;
        end
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign filtered_sample  = out_y_reg;
    assign error_sample     = out_e_reg;
    assign block_end        = out_last_reg;

endmodule

FILE: src/blms_ctrl.sv
// controller: sequences the filter dot product, result beat and block coefficient update
// depends on blms_pkg; drives blms_datapath through cmd_t
module blms_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output blms_pkg::cmd_t  cmd,
    input  blms_pkg::stat_t stat
);
    import blms_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_FMAC   = 10'b00_0000_0010,
        S_FDRAIN = 10'b00_0000_0100,
        S_FOUT   = 10'b00_0000_1000,
        S_UMAC   = 10'b00_0001_0000,
        S_UDRAIN = 10'b00_0010_0000,
        S_UGRAD  = 10'b00_0100_0000,
        S_USTEP  = 10'b00_1000_0000,
        S_UWAIT  = 10'b01_0000_0000,
        S_UCOEF  = 10'b10_0000_0000
    } state_t;

    localparam logic [TAP_W-1:0] LAST_IDX = TAP_W'(TAPS - 1);

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] pos_reg, pos_next;
    logic [TAP_W-1:0] cnt_reg, cnt_next;
    logic [TAP_W-1:0] k_reg, k_next;
    logic             in_fire;
    logic             pos_last;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign pos_last = (pos_reg == LAST_IDX);

    // state, position and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_FIR;
        cmd.last       = pos_last;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idx_a = HIST_W'(TAPS - 1) + HIST_W'(pos_reg);
                if (in_fire)
                begin
                    cmd.load_in = 1'b1;
                    cmd.acc_clr = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_FMAC;
                end
            end
            // window sample times coefficient, one tap a cycle
            S_FMAC:
            begin
                cmd.mul_en = 1'b1;
                cmd.idx_a  = HIST_W'(pos_reg) + HIST_W'(cnt_reg);
                cmd.idx_b  = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_FDRAIN;
                end
            end
            S_FDRAIN:
            begin
                state_next = S_FOUT;
            end
            // wait for a free output register, then store error
            S_FOUT:
            begin
                cmd.idx_b = pos_reg;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (pos_last)
                    begin
                        cmd.acc_clr = 1'b1;
                        cnt_next    = '0;
                        k_next      = '0;
                        state_next  = S_UMAC;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            // gradient for tap k: history times block error
            S_UMAC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GRAD;
                cmd.idx_a   = HIST_W'(cnt_reg) + HIST_W'(k_reg);
                cmd.idx_b   = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_UDRAIN;
                end
            end
            S_UDRAIN:
            begin
                state_next = S_UGRAD;
            end
            S_UGRAD:
            begin
                cmd.grad_load = 1'b1;
                state_next    = S_USTEP;
            end
            // step size times gradient
            S_USTEP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_STEP;
                state_next  = S_UWAIT;
            end
            S_UWAIT:
            begin
                state_next = S_UCOEF;
            end
            // saturating coefficient write, then next tap or history shift
            S_UCOEF:
            begin
                cmd.coef_we = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.idx_b   = k_reg;
                cnt_next    = '0;
                k_next      = k_reg + 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    cmd.hist_shift = 1'b1;
                    pos_next       = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_UMAC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a result beat is only loaded into a free output register
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending beat");

    // block position never leaves the block
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_IDX)
        else $error("block position out of range");

    // a sample that does not close a block returns straight to idle
    a_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOUT && stat.out_free && !pos_last) |=> state_reg == S_IDLE)
        else $error("update started mid block");

    // an accepted sample starts the filter dot product
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_FMAC && cnt_reg == '0))
        else $error("accepted sample did not start filtering");

    // the history shift comes only with the last coefficient write
    a_shift_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_shift |-> (cmd.coef_we && k_reg == LAST_IDX))
        else $error("history shifted early");

endmodule

FILE: src/block_lms_adaptive_fir_core.sv
// Block LMS adaptive FIR filter, q15, with one shared multiply-accumulate unit.
//
// Channels: in_ch (sink) takes one beat per sample with mic_sample and
// reference_sample; out_ch (source) gives one beat per sample with
// filtered_sample, error_sample and block_end. A beat moves at a rising edge
// with valid and ready both high. cfg_we/cfg_data write step_size (q15,
// unsigned) and must only be used while the block is idle.
//
// Timing: the result beat is registered in the output register after the
// FMAC, FDRAIN and FOUT states. The single MAC sets the rate; a new sample
// is taken only while the controller is idle, once the last one is done.
// The sample that closes a block (block_end=1) adds the coefficient update
// before the next sample is taken.
//
// Reset: history, coefficients and block errors clear to zero, step_size
// becomes 3, block position zero; no clearing pass is needed.
// Stall: a result waits in the output register; the next sample is still
// accepted and filtered, and waits for that register before finishing.
// depends on blms_pkg, blms_if, blms_ctrl and blms_datapath
module block_lms_adaptive_fir_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_data,
    blms_in_if.sink     in_ch,
    blms_out_if.source  out_ch
);
    import blms_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  ready;

    // sequencer
    blms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign in_ch.ready = ready;

    // storage, mac and output register
    blms_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .mic_sample       (in_ch.mic_sample),
        .reference_sample (in_ch.reference_sample),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .filtered_sample  (out_ch.filtered_sample),
        .error_sample     (out_ch.error_sample),
        .block_end        (out_ch.block_end)
    );

endmodule
